// File: rtl/hbsrc_pkg.sv
// shared types and constants for the h-bridge speed ramp controller
// used by the top level and by its port checker; no dependencies
package hbsrc_pkg;

	localparam int SPEED_W = 16;
	localparam int STEP_W  = SPEED_W + 1;
	localparam int TIME_W  = 32;
	localparam int PCT_W   = 7;
	localparam int MODE_W  = 3;
	localparam int CFG_W   = 16;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// mode encoding
	localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RUN_LAST = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TEST_FWD = 3'd4;
	localparam logic [MODE_W-1:0] MODE_TEST_REV = 3'd5;
	localparam logic [MODE_W-1:0] MODE_STOP     = 3'd6;
	localparam logic [MODE_W-1:0] MODE_PRE_DIR  = 3'd7;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_FULL_SCALE    = 2'd0;
	localparam logic [1:0] REG_RAMP_INTERVAL = 2'd1;
	localparam logic [1:0] REG_DWELL         = 2'd2;

	localparam logic [CFG_W-1:0] FULL_SCALE_RST    = 16'd1000;
	localparam logic [CFG_W-1:0] RAMP_INTERVAL_RST = 16'd100;
	localparam logic [CFG_W-1:0] DWELL_RST         = 16'd2000;
	// 80 percent of the full-scale reset value
	localparam logic [SPEED_W-1:0] TEST_TARGET_RST = 16'd800;

	// target * percent, at most 65535 * 127
	localparam int PROD_W = SPEED_W + PCT_W;

	// x / 100 as (x * DIV100_MUL) >> DIV100_SHIFT, exact for x below 2^23
	localparam int DIV100_SHIFT = 31;
	localparam int DIV100_MUL_W = 25;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 25'd21474837;

	// x / 5 as (x * DIV5_MUL) >> DIV5_SHIFT, exact for x below 2^18
	localparam int DIV5_SHIFT = 21;
	localparam int DIV5_MUL_W = 19;
	localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 19'd419431;

	typedef struct packed {
		logic                motor_select;
		logic [MODE_W-1:0]   mode;
		logic [SPEED_W-1:0]  target_speed;
		logic                direction_in;
		logic [MODE_W-1:0]   previous_mode;
		logic [TIME_W-1:0]   now_ms;
		logic                dwell_done;
	} item_t;

endpackage

// File: rtl/hbridge_speed_ramp_controller_top.sv
// h-bridge speed ramp controller: slew-limited speed per bridge, apb config
// depends on hbsrc_pkg
//
// an accepted input word passes stage 1, stage 2, stage 3 and the result register
// throughput: one word per cycle while the result side does not stall, including back-to-back words for one bridge
// the per-bridge speed and step time are read and written in the last stage only
// arst_n clears all valid flags, the kept speeds and step times, and sets the
// config registers to their defaults at once; no clearing pass is needed
module hbridge_speed_ramp_controller_top #(
	parameter int MOTOR_COUNT = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// config port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hbsrc_pkg::ADDR_W-1:0]       paddr,
	input  logic [hbsrc_pkg::DATA_W-1:0]       pwdata,
	output logic [hbsrc_pkg::DATA_W-1:0]       prdata,
	output logic                               pready,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               motor_select,
	input  logic [hbsrc_pkg::MODE_W-1:0]       mode,
	input  logic [hbsrc_pkg::SPEED_W-1:0]      target_speed,
	input  logic                               direction_in,
	input  logic [hbsrc_pkg::PCT_W-1:0]        accel_percent,
	input  logic [hbsrc_pkg::MODE_W-1:0]       previous_mode,
	input  logic [hbsrc_pkg::TIME_W-1:0]       dir_change_start,
	input  logic [hbsrc_pkg::TIME_W-1:0]       now_ms,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [hbsrc_pkg::SPEED_W-1:0]      speed_now,
	output logic                               forward_on,
	output logic                               reverse_on,
	output logic                               direction_out,
	output logic [hbsrc_pkg::MODE_W-1:0]       next_mode
);

	localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam int SW    = hbsrc_pkg::SPEED_W;
	localparam int STW   = hbsrc_pkg::STEP_W;
	localparam int TW    = hbsrc_pkg::TIME_W;
	localparam int DIVP_W = hbsrc_pkg::PROD_W + hbsrc_pkg::DIV100_MUL_W;
	localparam int TSTX_W = hbsrc_pkg::CFG_W + 2;
	localparam int TSTP_W = TSTX_W + hbsrc_pkg::DIV5_MUL_W;

	// ------------------------------------------------------------------
	// config registers
	// the test-mode target (80 percent of full scale) is worked out when
	// the full-scale register is written, so no divide sits in the item path
	// ------------------------------------------------------------------
	logic [hbsrc_pkg::CFG_W-1:0] vmax_q;
	logic [hbsrc_pkg::CFG_W-1:0] ramp_q;
	logic [hbsrc_pkg::CFG_W-1:0] dwell_q;
	logic [SW-1:0]               test_tgt_q;

	logic                        cfg_wr;
	logic [TSTX_W-1:0]           vmax_x4;
	logic [TSTP_W-1:0]           vmax_div5;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	// vmax * 80 / 100 is vmax * 4 / 5
	assign vmax_x4   = {pwdata[hbsrc_pkg::CFG_W-1:0], 2'b00};
	assign vmax_div5 = TSTP_W'(vmax_x4) * TSTP_W'(hbsrc_pkg::DIV5_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmax_q     <= hbsrc_pkg::FULL_SCALE_RST;
			ramp_q     <= hbsrc_pkg::RAMP_INTERVAL_RST;
			dwell_q    <= hbsrc_pkg::DWELL_RST;
			test_tgt_q <= hbsrc_pkg::TEST_TARGET_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				hbsrc_pkg::REG_FULL_SCALE: begin
					vmax_q     <= pwdata[hbsrc_pkg::CFG_W-1:0];
					test_tgt_q <= vmax_div5[hbsrc_pkg::DIV5_SHIFT +: SW];
				end
				hbsrc_pkg::REG_RAMP_INTERVAL: ramp_q  <= pwdata[hbsrc_pkg::CFG_W-1:0];
				hbsrc_pkg::REG_DWELL:         dwell_q <= pwdata[hbsrc_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			hbsrc_pkg::REG_FULL_SCALE:    prdata = {16'd0, vmax_q};
			hbsrc_pkg::REG_RAMP_INTERVAL: prdata = {16'd0, ramp_q};
			hbsrc_pkg::REG_DWELL:         prdata = {16'd0, dwell_q};
			default:                      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// pipeline handshake: each stage moves when the next one is empty or
	// moving, so bubbles close up and a held result does not block intake
	// until every stage is full
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic rdy_o, rdy_s3, rdy_s2, rdy_s1;

	assign rdy_o  = !out_valid_q || !out_stall;
	assign rdy_s3 = !v_s3 || rdy_o;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// stage 1: register the input word
	hbsrc_pkg::item_t            item_s1;
	logic [hbsrc_pkg::PCT_W-1:0] pct_s1;
	logic [TW-1:0]               dstart_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			item_s1.motor_select  <= motor_select;
			item_s1.mode          <= mode;
			item_s1.target_speed  <= target_speed;
			item_s1.direction_in  <= direction_in;
			item_s1.previous_mode <= previous_mode;
			item_s1.now_ms        <= now_ms;
			item_s1.dwell_done    <= 1'b0;
			pct_s1                <= accel_percent;
			dstart_s1             <= dir_change_start;
		end
	end

	// stage 2: target * percent, and the dwell check (no kept state needed)
	hbsrc_pkg::item_t                  item_s2;
	hbsrc_pkg::item_t                  item_s1_dw;
	logic [hbsrc_pkg::PROD_W-1:0]      prod_s2;
	logic [TW-1:0]                     dwell_elapsed;

	assign dwell_elapsed = item_s1.now_ms - dstart_s1;

	always_comb begin
		item_s1_dw            = item_s1;
		item_s1_dw.dwell_done = dwell_elapsed > TW'(dwell_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			item_s2 <= item_s1_dw;
			prod_s2 <= hbsrc_pkg::PROD_W'(item_s1.target_speed) *
				hbsrc_pkg::PROD_W'(pct_s1);
		end
	end

	// stage 3: divide by 100 through the reciprocal, floor the step at one
	hbsrc_pkg::item_t  item_s3;
	logic [STW-1:0]    step_s3;
	logic [DIVP_W-1:0] div_prod;
	logic [STW-1:0]    quot;

	assign div_prod = DIVP_W'(prod_s2) * DIVP_W'(hbsrc_pkg::DIV100_MUL);
	assign quot     = div_prod[hbsrc_pkg::DIV100_SHIFT +: STW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			item_s3 <= item_s2;
			step_s3 <= (quot == '0) ? STW'(1) : quot;
		end
	end

	// ------------------------------------------------------------------
	// last stage: read the bridge's kept speed and step time, take at most one
	// ramp step, write the speed and any moved step time back and load the result
	// register in the same edge, so the next word for that bridge sees the new values
	// ------------------------------------------------------------------
	logic [SW-1:0] speed_q     [MOTOR_COUNT];
	logic [TW-1:0] step_time_q [MOTOR_COUNT];

	function automatic logic [SW-1:0] slew(
		input logic [SW-1:0]  cur,
		input logic [SW-1:0]  tgt,
		input logic [STW-1:0] step
	);
		logic [STW-1:0] diff;
		logic [STW-1:0] res;
		begin
			res = {1'b0, tgt};
			if (cur > tgt) begin
				diff = {1'b0, cur} - {1'b0, tgt};
				if (diff > step) res = {1'b0, cur} - step;
			end else if (cur < tgt) begin
				diff = {1'b0, tgt} - {1'b0, cur};
				if (diff > step) res = {1'b0, cur} + step;
			end
			return res[SW-1:0];
		end
	endfunction

	logic [IDX_W-1:0] idx;
	logic             sel_ok;
	logic [SW-1:0]    cur;
	logic [TW-1:0]    step_elapsed;
	logic             due;
	logic [SW-1:0]    cur_nx;
	logic             time_upd;
	logic             dir_eff;
	logic [hbsrc_pkg::MODE_W-1:0] mode_nx;
	logic             fire;

	// a one-bit select only misses when there is a single bridge
	assign sel_ok = (MOTOR_COUNT > 1) || !item_s3.motor_select;
	assign idx    = IDX_W'(item_s3.motor_select);
	assign cur    = sel_ok ? speed_q[idx] : '0;
	assign step_elapsed = item_s3.now_ms - (sel_ok ? step_time_q[idx] : '0);
	assign due    = step_elapsed > TW'(ramp_q);
	assign fire   = v_s3 && rdy_o;

	always_comb begin
		cur_nx   = cur;
		time_upd = 1'b0;
		dir_eff  = item_s3.direction_in;
		mode_nx  = item_s3.mode;
		case (item_s3.mode)
			hbsrc_pkg::MODE_IDLE: begin
				// ramp down; the last step to zero leaves the step time alone
				if (due) begin
					if ({1'b0, cur} > step_s3) begin
						cur_nx   = SW'({1'b0, cur} - step_s3);
						time_upd = 1'b1;
					end else begin
						cur_nx = '0;
					end
				end
			end
			hbsrc_pkg::MODE_TEST_FWD, hbsrc_pkg::MODE_TEST_REV: begin
				dir_eff = (item_s3.mode == hbsrc_pkg::MODE_TEST_REV);
				if (due) begin
					cur_nx   = slew(cur, test_tgt_q, step_s3);
					time_upd = 1'b1;
				end
			end
			hbsrc_pkg::MODE_STOP: begin
				cur_nx = '0;
			end
			hbsrc_pkg::MODE_PRE_DIR: begin
				// speed held during the dwell, then dropped with the old mode back
				if (item_s3.dwell_done) begin
					cur_nx  = '0;
					mode_nx = item_s3.previous_mode;
				end
			end
			default: begin
				// the three run modes
				if (due) begin
					cur_nx   = slew(cur, item_s3.target_speed, step_s3);
					time_upd = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				speed_q[i]     <= '0;
				step_time_q[i] <= '0;
			end
		end else if (fire && sel_ok) begin
			speed_q[idx] <= cur_nx;
			if (time_upd) step_time_q[idx] <= item_s3.now_ms;
		end
	end

	// result register
	logic [SW-1:0]                speed_q_out;
	logic                         fwd_q, rev_q, dir_q;
	logic [hbsrc_pkg::MODE_W-1:0] mode_q;
	logic                         drive;

	// channels are driven in idle, run and test modes only
	assign drive = item_s3.mode <= hbsrc_pkg::MODE_TEST_REV;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_o) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (sel_ok) begin
				speed_q_out <= cur_nx;
				fwd_q       <= drive && !dir_eff;
				rev_q       <= drive && dir_eff;
				dir_q       <= dir_eff;
				mode_q      <= mode_nx;
			end else begin
				speed_q_out <= '0;
				fwd_q       <= 1'b0;
				rev_q       <= 1'b0;
				dir_q       <= 1'b0;
				mode_q      <= item_s3.mode;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign speed_now     = speed_q_out;
	assign forward_on    = fwd_q;
	assign reverse_on    = rev_q;
	assign direction_out = dir_q;
	assign next_mode     = mode_q;

endmodule

// File: rtl/hbsrc_checker.sv
// port-level checks for the h-bridge speed ramp controller, bound to the top
// depends on hbsrc_pkg and hbridge_speed_ramp_controller_top
module hbsrc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [hbsrc_pkg::SPEED_W-1:0] speed_now,
	input logic                          forward_on,
	input logic                          reverse_on,
	input logic [hbsrc_pkg::MODE_W-1:0]  next_mode
);

	// a held result word keeps its speed and its mode
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(speed_now) &&
			$stable(next_mode))
		else $error("result word changed while stalled");

	// no result word out of reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// never both bridge channels at once
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(forward_on && reverse_on))
		else $error("both channels enabled");

	// stop leaves the bridge off at zero speed
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && next_mode == hbsrc_pkg::MODE_STOP |->
			!forward_on && !reverse_on && speed_now == '0)
		else $error("stop result not off at zero speed");

endmodule

bind hbridge_speed_ramp_controller_top hbsrc_checker u_hbsrc_checker (.*);

// File: dv/hbsrc_ramp_checker.sv
`timescale 1ns / 100ps
// port checker for the h-bridge speed ramp controller: tracks config writes,
// predicts each result word and compares it; depends on hbsrc_pkg
module hbsrc_ramp_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hbsrc_pkg::ADDR_W-1:0]   paddr,
	input  logic [hbsrc_pkg::DATA_W-1:0]   pwdata,
	input  logic                           pready,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           motor_select,
	input  logic [hbsrc_pkg::MODE_W-1:0]   mode,
	input  logic [hbsrc_pkg::SPEED_W-1:0]  target_speed,
	input  logic                           direction_in,
	input  logic [hbsrc_pkg::PCT_W-1:0]    accel_percent,
	input  logic [hbsrc_pkg::MODE_W-1:0]   previous_mode,
	input  logic [hbsrc_pkg::TIME_W-1:0]   dir_change_start,
	input  logic [hbsrc_pkg::TIME_W-1:0]   now_ms,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [hbsrc_pkg::SPEED_W-1:0]  speed_now,
	input  logic                           forward_on,
	input  logic                           reverse_on,
	input  logic                           direction_out,
	input  logic [hbsrc_pkg::MODE_W-1:0]   next_mode,
	output int                             fail_count,
	output int                             pending,
	output int                             checked
);

	typedef struct packed {
		logic [hbsrc_pkg::SPEED_W-1:0] speed_now;
		logic                          forward_on;
		logic                          reverse_on;
		logic                          direction_out;
		logic [hbsrc_pkg::MODE_W-1:0]  next_mode;
	} speed_word_t;

	logic [hbsrc_pkg::CFG_W-1:0]   vel_max_q;
	logic [hbsrc_pkg::CFG_W-1:0]   ramp_ms_q;
	logic [hbsrc_pkg::CFG_W-1:0]   dwell_ms_q;
	logic [hbsrc_pkg::SPEED_W-1:0] speed_q     [2];
	logic [hbsrc_pkg::TIME_W-1:0]  step_time_q [2];
	speed_word_t                   expected_words [$];
	speed_word_t                   exp_w;

	function automatic int unsigned slew_toward(int unsigned cur, int unsigned tgt,
			int unsigned step_sz);
		if (cur > tgt)
			return (cur - tgt > step_sz) ? cur - step_sz : tgt;
		if (cur < tgt)
			return (tgt - cur > step_sz) ? cur + step_sz : tgt;
		return tgt;
	endfunction

	// advances the kept speed of one bridge and returns the result word
	function automatic speed_word_t ramp_predict(logic sel,
			logic [hbsrc_pkg::MODE_W-1:0] md, logic [hbsrc_pkg::SPEED_W-1:0] tgt,
			logic dir, logic [hbsrc_pkg::PCT_W-1:0] pct, logic [hbsrc_pkg::MODE_W-1:0] prev,
			logic [hbsrc_pkg::TIME_W-1:0] dstart, logic [hbsrc_pkg::TIME_W-1:0] now);
		speed_word_t                  w;
		int unsigned                  cur, step_sz, tgt_u, pct_u, vel_u;
		logic [hbsrc_pkg::TIME_W-1:0] since_step, since_dir;
		logic                         due, eff_dir, drive;
		logic [hbsrc_pkg::MODE_W-1:0] nxt;
		cur        = 32'(speed_q[sel]);
		tgt_u      = 32'(tgt);
		pct_u      = 32'(pct);
		vel_u      = 32'(vel_max_q);
		step_sz    = tgt_u * pct_u / 100;
		if (step_sz == 0)
			step_sz = 1;
		since_step = now - step_time_q[sel];
		since_dir  = now - dstart;
		due        = since_step > 32'(ramp_ms_q);
		eff_dir    = dir;
		nxt        = md;
		if (md == hbsrc_pkg::MODE_IDLE) begin
			// the step time only moves when a real decrement happens
			if (due) begin
				if (cur > step_sz) begin
					cur = cur - step_sz;
					step_time_q[sel] = now;
				end else begin
					cur = 0;
				end
			end
		end else if (md <= hbsrc_pkg::MODE_RUN_LAST) begin
			if (due) begin
				cur = slew_toward(cur, tgt_u, step_sz);
				step_time_q[sel] = now;
			end
		end else if (md <= hbsrc_pkg::MODE_TEST_REV) begin
			eff_dir = (md == hbsrc_pkg::MODE_TEST_REV);
			if (due) begin
				cur = slew_toward(cur, vel_u * 80 / 100, step_sz);
				step_time_q[sel] = now;
			end
		end else if (md == hbsrc_pkg::MODE_STOP) begin
			cur = 0;
		end else if (since_dir > 32'(dwell_ms_q)) begin
			nxt = prev;
			cur = 0;
		end
		speed_q[sel]    = 16'(cur);
		drive           = (md <= hbsrc_pkg::MODE_TEST_REV);
		w.speed_now     = 16'(cur);
		w.forward_on    = drive && !eff_dir;
		w.reverse_on    = drive && eff_dir;
		w.direction_out = eff_dir;
		w.next_mode     = nxt;
		return w;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			fail_count++;
			if (fail_count <= 40)
				$display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_max_q  = hbsrc_pkg::FULL_SCALE_RST;
			ramp_ms_q  = hbsrc_pkg::RAMP_INTERVAL_RST;
			dwell_ms_q = hbsrc_pkg::DWELL_RST;
			for (int i = 0; i < 2; i++) begin
				speed_q[i]     = '0;
				step_time_q[i] = '0;
			end
			expected_words.delete();
			fail_count = 0;
			checked    = 0;
			pending    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					hbsrc_pkg::REG_FULL_SCALE: begin
						vel_max_q = pwdata[hbsrc_pkg::CFG_W-1:0];
					end
					hbsrc_pkg::REG_RAMP_INTERVAL: begin
						ramp_ms_q = pwdata[hbsrc_pkg::CFG_W-1:0];
					end
					hbsrc_pkg::REG_DWELL: begin
						dwell_ms_q = pwdata[hbsrc_pkg::CFG_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 40)
						$display("%0t: result word with none expected, expected none got speed %0d",
							$time, speed_now);
				end else begin
					exp_w = expected_words.pop_front();
					checked++;
					check_field("speed_now", 32'(exp_w.speed_now), 32'(speed_now));
					check_field("forward_on", 32'(exp_w.forward_on), 32'(forward_on));
					check_field("reverse_on", 32'(exp_w.reverse_on), 32'(reverse_on));
					check_field("direction_out", 32'(exp_w.direction_out),
						32'(direction_out));
					check_field("next_mode", 32'(exp_w.next_mode), 32'(next_mode));
				end
			end
			if (in_valid && !in_stall)
				expected_words.push_back(ramp_predict(motor_select, mode, target_speed,
					direction_in, accel_percent, previous_mode, dir_change_start, now_ms));
			pending = expected_words.size();
		end
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// testbench top for the h-bridge speed ramp controller: clock, reset, apb
// setup, control word stimulus and verdict; uses hbsrc_pkg and hbsrc_ramp_checker
module tb;

	localparam int CYCLE_LIMIT = 1000000;

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           psel          = 1'b0;
	logic                           penable       = 1'b0;
	logic                           pwrite        = 1'b0;
	logic [hbsrc_pkg::ADDR_W-1:0]   paddr         = '0;
	logic [hbsrc_pkg::DATA_W-1:0]   pwdata        = '0;
	logic [hbsrc_pkg::DATA_W-1:0]   prdata;
	logic                           pready;
	logic                           in_valid      = 1'b0;
	logic                           in_stall;
	logic                           motor_select  = 1'b0;
	logic [hbsrc_pkg::MODE_W-1:0]   mode          = hbsrc_pkg::MODE_IDLE;
	logic [hbsrc_pkg::SPEED_W-1:0]  target_speed  = '0;
	logic                           direction_in  = 1'b0;
	logic [hbsrc_pkg::PCT_W-1:0]    accel_percent = '0;
	logic [hbsrc_pkg::MODE_W-1:0]   previous_mode = hbsrc_pkg::MODE_IDLE;
	logic [hbsrc_pkg::TIME_W-1:0]   dir_change_start = '0;
	logic [hbsrc_pkg::TIME_W-1:0]   now_ms        = '0;
	logic                           out_valid;
	logic                           out_stall     = 1'b0;
	logic [hbsrc_pkg::SPEED_W-1:0]  speed_now;
	logic                           forward_on;
	logic                           reverse_on;
	logic                           direction_out;
	logic [hbsrc_pkg::MODE_W-1:0]   next_mode;

	int fail_count;
	int pending;
	int checked;

	// stimulus bookkeeping
	int                           words_sent    = 0;
	int                           settings_used = 1;
	int                           cycle_count   = 0;
	bit                           quiet         = 1'b0;  // no gaps and no stalls while set
	logic [hbsrc_pkg::TIME_W-1:0] clock_ms      = '0;
	int unsigned                  ramp_set      = 32'(hbsrc_pkg::RAMP_INTERVAL_RST);
	int unsigned                  dwell_set     = 32'(hbsrc_pkg::DWELL_RST);
	int                           stall_left    = 0;
	bit                           stall_hold    = 1'b0;

	hbridge_speed_ramp_controller_top u_dut (.*);
	hbsrc_ramp_checker u_checker (.*);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// mostly short waits, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side back-pressure: random stall stretches, off during quiet spells
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_hold = ($urandom_range(99) < 35);
			stall_left = stall_hold ? pick_gap() + 1 : $urandom_range(1, 8);
		end
		stall_left = stall_left - 1;
		out_stall <= (quiet || !arst_n) ? 1'b0 : stall_hold;
	end

	// one control word; starts and ends right after a rising edge
	task automatic send_word(logic sel, logic [hbsrc_pkg::MODE_W-1:0] md,
			logic [hbsrc_pkg::SPEED_W-1:0] tgt, logic dir, logic [hbsrc_pkg::PCT_W-1:0] pct,
			logic [hbsrc_pkg::MODE_W-1:0] prev, logic [hbsrc_pkg::TIME_W-1:0] dstart,
			logic [hbsrc_pkg::TIME_W-1:0] now);
		int gap;
		bit taken;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid         <= 1'b1;
		motor_select     <= sel;
		mode             <= md;
		target_speed     <= tgt;
		direction_in     <= dir;
		accel_percent    <= pct;
		previous_mode    <= prev;
		dir_change_start <= dstart;
		now_ms           <= now;
		// stall is stable between the falling edge and the next rising edge
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		words_sent++;
	endtask

	// block idle: wait until every expected word is back, then let the clock run on idle
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [hbsrc_pkg::CFG_W-1:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), value};  // upper bits are ignored by the block
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_setting(logic [hbsrc_pkg::CFG_W-1:0] vel,
			logic [hbsrc_pkg::CFG_W-1:0] ramp, logic [hbsrc_pkg::CFG_W-1:0] dwell);
		settle();
		reg_write(hbsrc_pkg::REG_FULL_SCALE, vel);
		reg_write(hbsrc_pkg::REG_RAMP_INTERVAL, ramp);
		reg_write(hbsrc_pkg::REG_DWELL, dwell);
		ramp_set  = 32'(ramp);
		dwell_set = 32'(dwell);
		settings_used++;
	endtask

	function automatic logic [hbsrc_pkg::SPEED_W-1:0] pick_target();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return '1;
		if (r < 30)
			return 16'($urandom_range(1, 50));
		return 16'($urandom);
	endfunction

	// percent above 100 lets the step exceed the speed range
	function automatic logic [hbsrc_pkg::PCT_W-1:0] pick_pct();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 14)
			return 7'($urandom_range(101, 127));
		if (r < 20)
			return 7'd100;
		return 7'($urandom_range(1, 100));
	endfunction

	// moves the millisecond clock, with the odd jump anywhere in the 32-bit range
	task automatic advance_clock(int unsigned span);
		if ($urandom_range(99) < 3)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms + $urandom_range(0, span);
	endtask

	// random part: mostly coherent scenarios on one bridge, some plain noise
	task automatic run_random(int n_items);
		int                            first, kind, len;
		logic                          bridge, dir, sel;
		logic [hbsrc_pkg::MODE_W-1:0]  md, prev;
		logic [hbsrc_pkg::SPEED_W-1:0] tgt;
		logic [hbsrc_pkg::PCT_W-1:0]   pct;
		logic [hbsrc_pkg::TIME_W-1:0]  dstart;
		first = words_sent;
		while (words_sent - first < n_items) begin
			kind   = $urandom_range(99);
			bridge = 1'($urandom_range(1));
			tgt    = pick_target();
			pct    = pick_pct();
			dir    = 1'($urandom_range(1));
			prev   = 3'($urandom);
			len    = $urandom_range(4, 16);
			quiet  = ($urandom_range(9) == 0);
			dstart = clock_ms;
			if (kind < 35)
				md = hbsrc_pkg::MODE_IDLE + 3'($urandom_range(1, hbsrc_pkg::MODE_RUN_LAST));
			else if (kind < 50)
				md = $urandom_range(1) ? hbsrc_pkg::MODE_TEST_REV : hbsrc_pkg::MODE_TEST_FWD;
			else if (kind < 62)
				md = hbsrc_pkg::MODE_IDLE;
			else if (kind < 67) begin
				md  = hbsrc_pkg::MODE_STOP;
				len = 1;
			end else if (kind < 82)
				md = hbsrc_pkg::MODE_PRE_DIR;
			else
				len = 3;
			for (int i = 0; i < len; i++) begin
				sel = ($urandom_range(9) < 8) ? bridge : !bridge;
				if (kind >= 82) begin
					// noise: every field random, the clock anywhere
					md       = 3'($urandom);
					tgt      = 16'($urandom);
					pct      = 7'($urandom);
					dir      = 1'($urandom_range(1));
					prev     = 3'($urandom);
					dstart   = $urandom;
					clock_ms = $urandom;
				end else if (md == hbsrc_pkg::MODE_PRE_DIR) begin
					advance_clock(dwell_set / 3 + 4);
				end else begin
					advance_clock(ramp_set / 5 + 4);
				end
				send_word(sel, md, tgt, dir, pct, prev, dstart, clock_ms);
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed words at the reset settings
		send_word(1'b0, hbsrc_pkg::MODE_IDLE + 3'd1, 16'hFFFF, 1'b0, 7'd100,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'd101);
		send_word(1'b0, hbsrc_pkg::MODE_IDLE + 3'd2, 16'h0000, 1'b0, 7'd0,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'd150);
		// zero step turns into a step of one
		send_word(1'b0, hbsrc_pkg::MODE_RUN_LAST, 16'h0000, 1'b1, 7'd0,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'd300);
		// idle with a step wider than the speed range
		send_word(1'b0, hbsrc_pkg::MODE_IDLE, 16'hFFFF, 1'b0, 7'd127,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'd500);
		// test modes force the direction, ramp step taken or not
		send_word(1'b1, hbsrc_pkg::MODE_TEST_FWD, 16'd1000, 1'b1, 7'd10,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'd200);
		send_word(1'b1, hbsrc_pkg::MODE_TEST_REV, 16'd1000, 1'b0, 7'd10,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'd250);
		send_word(1'b1, hbsrc_pkg::MODE_TEST_REV, 16'd1000, 1'b0, 7'd10,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'd400);
		send_word(1'b1, hbsrc_pkg::MODE_STOP, 16'd1000, 1'b1, 7'd10,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'd401);
		send_word(1'b0, hbsrc_pkg::MODE_IDLE + 3'd1, 16'd5000, 1'b0, 7'd50,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'd700);
		// direction change: running, exactly at the dwell, then past it
		send_word(1'b0, hbsrc_pkg::MODE_PRE_DIR, 16'd5000, 1'b1, 7'd50,
			hbsrc_pkg::MODE_RUN_LAST, 32'd1000, 32'd1000);
		send_word(1'b0, hbsrc_pkg::MODE_PRE_DIR, 16'd5000, 1'b1, 7'd50,
			hbsrc_pkg::MODE_TEST_REV, 32'd1000, 32'd3000);
		send_word(1'b0, hbsrc_pkg::MODE_PRE_DIR, 16'd5000, 1'b1, 7'd50,
			hbsrc_pkg::MODE_TEST_REV, 32'd1000, 32'd3001);
		// millisecond clock wrapping
		send_word(1'b0, hbsrc_pkg::MODE_IDLE + 3'd1, 16'd5000, 1'b0, 7'd50,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'hFFFF_FFF0);
		send_word(1'b0, hbsrc_pkg::MODE_IDLE + 3'd1, 16'd5000, 1'b0, 7'd50,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'h0000_0060);
		// snap onto a speed already at its target
		send_word(1'b0, hbsrc_pkg::MODE_IDLE + 3'd2, 16'd5000, 1'b0, 7'd50,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'h0000_0100);
		send_word(1'b0, hbsrc_pkg::MODE_IDLE, 16'd5000, 1'b0, 7'd10,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'h0000_0200);
		send_word(1'b0, hbsrc_pkg::MODE_IDLE, 16'd5000, 1'b0, 7'd10,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'h0000_0201);
		send_word(1'b0, hbsrc_pkg::MODE_PRE_DIR, 16'hFFFF, 1'b1, 7'd127,
			hbsrc_pkg::MODE_PRE_DIR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// start time just after now reads as a very long dwell
		send_word(1'b1, hbsrc_pkg::MODE_PRE_DIR, 16'h0000, 1'b0, 7'd0,
			hbsrc_pkg::MODE_IDLE, 32'd1, 32'd0);
		send_word(1'b1, hbsrc_pkg::MODE_TEST_FWD, 16'hFFFF, 1'b1, 7'd127,
			hbsrc_pkg::MODE_IDLE, 32'd0, 32'h8000_0000);
		clock_ms = 32'h8000_0100;

		run_random(450);
		apply_setting(16'hFFFF, 16'h0000, 16'h0000);
		run_random(300);
		apply_setting(16'h0000, 16'hFFFF, 16'hFFFF);
		run_random(200);
		apply_setting(16'($urandom), 16'($urandom_range(0, 50)), 16'($urandom_range(0, 400)));
		run_random(300);
		apply_setting(hbsrc_pkg::FULL_SCALE_RST, hbsrc_pkg::RAMP_INTERVAL_RST,
			hbsrc_pkg::DWELL_RST);
		run_random(300);

		settle();
		$display("summary: %0d control words on both bridges, all modes, %0d register settings",
			words_sent, settings_used);
		$display("summary: %0d result words compared, %0d mismatches", checked, fail_count);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: hbridge_speed_ramp_controller_top.f
rtl/hbsrc_pkg.sv
rtl/hbridge_speed_ramp_controller_top.sv
rtl/hbsrc_checker.sv
dv/hbsrc_ramp_checker.sv
dv/tb.sv
